[rtl/tpd_pkg.sv]
package tpd_pkg;

   localparam int SampleWidth  = 16;
   localparam int CordicStages = 16;
   localparam int NumStages    = (CordicStages < 24) ? CordicStages : 24;
   localparam int ProdShift    = (2 * SampleWidth > 58) ? 2 * SampleWidth - 58 : 0;
   localparam int VecWidth     = 2 * SampleWidth + 4;
   localparam int CosWidth     = 34;
   localparam int MagWidth     = SampleWidth + 12;
   localparam int LevelWidth   = 18;
   localparam int PhaseWidth   = 16;
   localparam int LaneCount    = 5;
   localparam int PipeDepth    = NumStages + 1;

   localparam logic signed [31:0] HalfPi  = 32'sd1073741824;
   localparam logic signed [CosWidth-1:0] GainQ30 = CosWidth'(652032874);
   localparam logic [15:0] GainQ16 = 16'd39797;

   typedef logic signed [VecWidth-1:0] vec_type;
   typedef logic signed [31:0] angle_type;

   function automatic angle_type atan_entry(input int idx);
      case (idx)
         0: atan_entry = 32'sd536870912;
         1: atan_entry = 32'sd316933406;
         2: atan_entry = 32'sd167458907;
         3: atan_entry = 32'sd85004756;
         4: atan_entry = 32'sd42667331;
         5: atan_entry = 32'sd21354465;
         6: atan_entry = 32'sd10679838;
         7: atan_entry = 32'sd5340245;
         8: atan_entry = 32'sd2670163;
         9: atan_entry = 32'sd1335087;
         10: atan_entry = 32'sd667544;
         11: atan_entry = 32'sd333772;
         12: atan_entry = 32'sd166886;
         13: atan_entry = 32'sd83443;
         14: atan_entry = 32'sd41722;
         15: atan_entry = 32'sd20861;
         16: atan_entry = 32'sd10430;
         17: atan_entry = 32'sd5215;
         18: atan_entry = 32'sd2608;
         19: atan_entry = 32'sd1304;
         20: atan_entry = 32'sd652;
         21: atan_entry = 32'sd326;
         22: atan_entry = 32'sd163;
         23: atan_entry = 32'sd81;
         default: atan_entry = 32'sd0;
      endcase
   endfunction

endpackage

[rtl/tpd_vector_lane.sv]
// Pipelined vectoring CORDIC, held while advance is low: angle and raw length.
module tpd_vector_lane import tpd_pkg::*; (
   input  logic      clock,
   input  logic      advance,
   input  vec_type   x_in,
   input  vec_type   y_in,
   output angle_type angle_out,
   output vec_type   len_out
);
   vec_type   x_ff [PipeDepth];
   vec_type   y_ff [PipeDepth];
   angle_type z_ff [PipeDepth];
   logic      zero_ff [PipeDepth];

   vec_type   x0_in, y0_in;
   angle_type z0_in;

   always_comb begin
      x0_in = x_in;
      y0_in = y_in;
      z0_in = '0;
      if (x_in < 0) begin
         if (y_in >= 0) begin
            x0_in = y_in; y0_in = -x_in; z0_in = HalfPi;
         end else begin
            x0_in = -y_in; y0_in = x_in; z0_in = -HalfPi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
         for (int i = 0; i < NumStages; i++) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   assign angle_out = zero_ff[NumStages] ? '0 : z_ff[NumStages];
   assign len_out   = zero_ff[NumStages] ? '0 : x_ff[NumStages];
endmodule

[rtl/tpd_cos_lane.sv]
// Pipelined rotation CORDIC cosine with quadrant fold; Q30 result.
module tpd_cos_lane import tpd_pkg::*; (
   input  logic                       clock,
   input  logic                       advance,
   input  angle_type                  angle_in,
   output logic signed [CosWidth-1:0] cos_out
);
   typedef logic signed [CosWidth-1:0] cw_type;
   cw_type x_ff [PipeDepth];
   cw_type y_ff [PipeDepth];
   logic signed [33:0] d_ff [PipeDepth];
   logic neg_ff [PipeDepth];

   logic signed [33:0] d0_in;
   logic neg0_in;

   always_comb begin
      d0_in   = 34'(angle_in);
      neg0_in = 1'b0;
      if (angle_in > HalfPi) begin
         d0_in = 34'(angle_in) - 34'(HalfPi) - 34'(HalfPi); neg0_in = 1'b1;
      end else if (angle_in < -HalfPi) begin
         d0_in = 34'(angle_in) + 34'(HalfPi) + 34'(HalfPi); neg0_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= GainQ30; y_ff[0] <= '0;
         d_ff[0] <= d0_in;   neg_ff[0] <= neg0_in;
         for (int i = 0; i < NumStages; i++) begin
            if (d_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               d_ff[i+1] <= d_ff[i] - 34'(atan_entry(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               d_ff[i+1] <= d_ff[i] + 34'(atan_entry(i));
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   assign cos_out = neg_ff[NumStages] ? -x_ff[NumStages] : x_ff[NumStages];
endmodule

[rtl/three_point_dixon_voxel.sv]
// Three-point Dixon water/fat separation, one voxel per item. The block is a
// fully stalled pipeline and takes one item every cycle while the output is
// taken. From accept to result an item passes the echo-product register, five
// vectoring CORDIC lanes (three magnitudes, two echo-product angles) side by
// side, the gain and argument register, a cosine CORDIC lane, then merge
// registers forming psi, the levels and the half phase. The whole pipe
// advances on one enable, so a stalled output holds every stage. No reset
// pass; ready only follows the output register.
module three_point_dixon_voxel import tpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // echo0_re, echo0_im, echo1_re, echo1_im, echo2_re, echo2_im
   input  logic [6*SampleWidth-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // field_phase[15:0], water_level[33:16], fat_level[51:34], pad to 56
   output logic [55:0] rsp_tdata,
   // zero_reference
   output logic        rsp_tuser
);
   localparam int Total = 2 * PipeDepth + 4;
   typedef logic signed [SampleWidth-1:0] smp_type;

   logic advance;
   logic [Total-1:0] valid_ff;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[Total-1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= {valid_ff[Total-2:0], req_tvalid};
   end

   smp_type r0, i0, r1, i1, r2, i2;
   assign r0 = req_tdata[0*SampleWidth +: SampleWidth];
   assign i0 = req_tdata[1*SampleWidth +: SampleWidth];
   assign r1 = req_tdata[2*SampleWidth +: SampleWidth];
   assign i1 = req_tdata[3*SampleWidth +: SampleWidth];
   assign r2 = req_tdata[4*SampleWidth +: SampleWidth];
   assign i2 = req_tdata[5*SampleWidth +: SampleWidth];

   // stage A: echo products (one multiplier per term) and scaled echoes
   vec_type lx_ff [LaneCount];
   vec_type ly_ff [LaneCount];
   logic    zref_ff [Total];

   function automatic vec_type pmul(input smp_type a, input smp_type b);
      logic signed [2*SampleWidth-1:0] p;
      p = a * b;
      pmul = VecWidth'(p >>> ProdShift);
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         lx_ff[0] <= VecWidth'(r0) <<< 8; ly_ff[0] <= VecWidth'(i0) <<< 8;
         lx_ff[1] <= VecWidth'(r1) <<< 8; ly_ff[1] <= VecWidth'(i1) <<< 8;
         lx_ff[2] <= VecWidth'(r2) <<< 8; ly_ff[2] <= VecWidth'(i2) <<< 8;
         lx_ff[3] <= pmul(r2, r0) + pmul(i2, i0);
         ly_ff[3] <= pmul(i2, r0) - pmul(r2, i0);
         lx_ff[4] <= pmul(r1, r0) + pmul(i1, i0);
         ly_ff[4] <= pmul(i1, r0) - pmul(r1, i0);
         zref_ff[0] <= (r0 == 0) && (i0 == 0);
         for (int k = 1; k < Total; k++) zref_ff[k] <= zref_ff[k-1];
      end
   end

   angle_type ang [LaneCount];
   vec_type   len [LaneCount];

   for (genvar g = 0; g < LaneCount; g++) begin : g_lane
      tpd_vector_lane u_lane (
         .clock(clock), .advance(advance), .x_in(lx_ff[g]), .y_in(ly_ff[g]),
         .angle_out(ang[g]), .len_out(len[g]));
   end

   // stage B: magnitude gain multiply, cosine argument
   logic signed [VecWidth+17:0] mp_ff [3];
   angle_type carg_ff, z2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++)
            mp_ff[k] <= (VecWidth+18)'(len[k]) * $signed({2'b0, GainQ16}) + 32768;
         carg_ff <= ang[4] - (ang[3] >>> 1);
         z2_ff   <= ang[3];
      end
   end

   logic signed [CosWidth-1:0] cosv;
   tpd_cos_lane u_cos (.clock(clock), .advance(advance), .angle_in(carg_ff),
      .cos_out(cosv));

   // align magnitudes and phase with cosine lane
   logic signed [MagWidth-1:0] m_ff [PipeDepth][3];
   angle_type z2d_ff [PipeDepth];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) m_ff[0][k] <= MagWidth'(mp_ff[k] >>> 16);
         z2d_ff[0] <= z2_ff;
         for (int s = 1; s < PipeDepth; s++) begin
            m_ff[s] <= m_ff[s-1];
            z2d_ff[s] <= z2d_ff[s-1];
         end
      end
   end

   // merge C: psi, product, magnitude sum and half phase
   logic signed [20:0] psi;
   logic signed [MagWidth+21:0] bp_ff;
   logic signed [MagWidth+1:0] a_ff;
   logic signed [PhaseWidth-1:0] ph_ff, ph2_ff;
   logic zr;
   assign zr  = zref_ff[Total-3];
   assign psi = zr ? 21'sd65536 : 21'((cosv + 8192) >>> 14);
   always_ff @(posedge clock) begin
      if (advance) begin
         bp_ff <= (MagWidth+22)'(psi) * (MagWidth+22)'(m_ff[PipeDepth-1][1]) + 32768;
         a_ff  <= (MagWidth+2)'(m_ff[PipeDepth-1][0]) + (MagWidth+2)'(m_ff[PipeDepth-1][2]);
         ph_ff <= zr ? '0 : PhaseWidth'((34'(z2d_ff[PipeDepth-1]) + 65536) >>> 17);
      end
   end

   function automatic logic [LevelWidth-1:0] sat(input logic signed [MagWidth+23:0] v);
      logic signed [MagWidth+23:0] s;
      s = (v + 512) >>> 10;
      if (s > 131071) sat = 18'h1FFFF;
      else if (s < -131072) sat = 18'h20000;
      else sat = s[LevelWidth-1:0];
   endfunction

   logic signed [MagWidth+23:0] bb, aa;
   logic [LevelWidth-1:0] water_ff, fat_ff;
   assign bb = (MagWidth+24)'(bp_ff >>> 16);
   assign aa = (MagWidth+24)'(a_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         water_ff <= sat(aa + 2 * bb);
         fat_ff   <= sat(aa - 2 * bb);
         ph2_ff   <= ph_ff;
      end
   end

   assign rsp_tdata = {4'b0, fat_ff, water_ff, ph2_ff};
   assign rsp_tuser = zref_ff[Total-1];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("ready low with empty output");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == 16'd0)
      else $error("phase not zero for zero reference");
endmodule

[dv/tb_three_point_dixon_voxel.sv]
`timescale 1ns / 100ps

module tb_three_point_dixon_voxel;
   import tpd_pkg::*;

   localparam int NumRandom = 1850;
   localparam int CycleLimit = 400000;
   localparam int Latency = 2 * (NumStages + 1) + 12;

   typedef struct packed {
      logic signed [15:0] phase;
      logic signed [17:0] water;
      logic signed [17:0] fat;
      logic               zero_ref;
   } voxel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [6*SampleWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic rsp_tuser;

   // items waiting to be offered, and results waiting to arrive
   logic [6*SampleWidth-1:0] voxel_queue[$];
   voxel_result_type expected_results[$];

   int cycle_count = 0;
   int error_count = 0;
   int sent_count = 0;
   int got_count = 0;
   int zero_ref_count = 0;
   int sat_count = 0;
   bit quiet_phase = 1'b0;    // no idling at the end of the run
   bit hold_off = 1'b0;       // long receiver stall
   int send_idle = 0;
   int recv_idle = 0;

   three_point_dixon_voxel u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor: bit-exact fixed-point Dixon separation
   // ---------------------------------------------------------------

   // wrap to a 32-bit binary angle (2^31 = pi)
   function automatic longint wrap_angle(input longint v);
      logic signed [31:0] w;
      w = v[31:0];
      return longint'(w);
   endfunction

   function automatic longint atan_step(input int i);
      longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                          333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                          1304, 652, 326, 163, 81};
      return tab[i];
   endfunction

   // vectoring CORDIC; returns angle and gives the unscaled length
   function automatic longint cordic_angle(input longint xi, input longint yi,
                                           output longint len);
      longint x, y, z, t, dx, dy;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0) begin
         len = 0;
         return 0;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = HalfPi;
         end else begin
            x = -y;
            y = t;
            z = -longint'(HalfPi);
         end
      end
      for (int i = 0; i < NumStages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += atan_step(i);
         end else begin
            x -= dx;
            y += dy;
            z -= atan_step(i);
         end
      end
      len = x;
      return wrap_angle(z);
   endfunction

   // rotation CORDIC cosine in Q30, argument folded into [-pi/2, pi/2]
   function automatic longint cosine_q30(input longint arg);
      longint d, x, y, dx, dy;
      bit neg;
      neg = 1'b0;
      x = 652032874;
      y = 0;
      d = wrap_angle(arg);
      if (d > HalfPi) begin
         d -= 2 * longint'(HalfPi);
         neg = 1'b1;
      end else if (d < -longint'(HalfPi)) begin
         d += 2 * longint'(HalfPi);
         neg = 1'b1;
      end
      for (int i = 0; i < NumStages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (d >= 0) begin
            x -= dx;
            y += dy;
            d -= atan_step(i);
         end else begin
            x += dx;
            y -= dy;
            d += atan_step(i);
         end
      end
      return neg ? -x : x;
   endfunction

   function automatic longint echo_magnitude(input longint re, input longint im);
      longint len, ang;
      ang = cordic_angle(re * 256, im * 256, len);
      return (len * 39797 + 32768) >>> 16;
   endfunction

   function automatic longint clamp_level(input longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic voxel_result_type separate_voxel(input logic [6*SampleWidth-1:0] d);
      longint r0, i0, r1, i1, r2, i2, m0, m1, m2;
      longint z1, z2, psi, ph, a, b, w, f, dummy;
      longint p1r, p1i, p2r, p2i;
      voxel_result_type res;
      r0 = longint'($signed(d[15:0]));
      i0 = longint'($signed(d[31:16]));
      r1 = longint'($signed(d[47:32]));
      i1 = longint'($signed(d[63:48]));
      r2 = longint'($signed(d[79:64]));
      i2 = longint'($signed(d[95:80]));
      m0 = echo_magnitude(r0, i0);
      m1 = echo_magnitude(r1, i1);
      m2 = echo_magnitude(r2, i2);
      psi = 65536;
      ph = 0;
      res.zero_ref = (r0 == 0 && i0 == 0);
      if (!res.zero_ref) begin
         p2r = (r2 * r0 >>> ProdShift) + (i2 * i0 >>> ProdShift);
         p2i = (i2 * r0 >>> ProdShift) - (r2 * i0 >>> ProdShift);
         p1r = (r1 * r0 >>> ProdShift) + (i1 * i0 >>> ProdShift);
         p1i = (i1 * r0 >>> ProdShift) - (r1 * i0 >>> ProdShift);
         z2 = cordic_angle(p2r, p2i, dummy);
         z1 = cordic_angle(p1r, p1i, dummy);
         psi = (cosine_q30(z1 - (z2 >>> 1)) + 8192) >>> 14;
         ph = (z2 + 65536) >>> 17;
      end
      a = m0 + m2;
      b = (psi * m1 + 32768) >>> 16;
      w = clamp_level((a + 2 * b + 512) >>> 10);
      f = clamp_level((a - 2 * b + 512) >>> 10);
      res.phase = ph[15:0];
      res.water = w[17:0];
      res.fat = f[17:0];
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus build-up
   // ---------------------------------------------------------------
   function automatic logic [15:0] rand_part(input int mode);
      case (mode)
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 15)) - 16'd8;   // tiny values
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [6*SampleWidth-1:0] pack_echoes(
      input logic [15:0] r0, i0, r1, i1, r2, i2);
      return {i2, r2, i1, r1, i0, r0};
   endfunction

   // ---------------------------------------------------------------
   // Driver: offers the queue, with random gaps except near the end
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(separate_voxel(req_tdata));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_tvalid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
               send_idle = $urandom_range(0, 3);
               req_tvalid <= 1'b0;
            end else if (voxel_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= voxel_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor and receiver back-pressure
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      voxel_result_type exp_r;
      voxel_result_type act;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            act.phase = rsp_tdata[15:0];
            act.water = rsp_tdata[33:16];
            act.fat = rsp_tdata[51:34];
            act.zero_ref = rsp_tuser;
            got_count++;
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: data %h user %b",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (act.zero_ref) zero_ref_count++;
               if (exp_r.water == 18'sh1ffff || exp_r.fat == -18'sh20000)
                  sat_count++;
               if (act.phase !== exp_r.phase) begin
                  $error("field_phase exp %0d got %0d", exp_r.phase, act.phase);
                  error_count++;
               end
               if (act.water !== exp_r.water) begin
                  $error("water_level exp %0d got %0d", exp_r.water, act.water);
                  error_count++;
               end
               if (act.fat !== exp_r.fat) begin
                  $error("fat_level exp %0d got %0d", exp_r.fat, act.fat);
                  error_count++;
               end
               if (act.zero_ref !== exp_r.zero_ref) begin
                  $error("zero_reference exp %0b got %0b", exp_r.zero_ref,
                         act.zero_ref);
                  error_count++;
               end
            end
         end
         // one assignment per step to rsp_tready
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (recv_idle > 0) begin
            recv_idle--;
            rsp_tready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            recv_idle = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver stall so the pipe fills and req_tready drops
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      wait (sent_count >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      while (stall_cycles < 3 * Latency) begin
         @(posedge clock);
         stall_cycles++;
      end
      hold_off <= 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int total;
      int wait_cycles;
      logic [15:0] p[6];
      logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero echo0, zero products, all-zero voxel
      voxel_queue.push_back(pack_echoes(0, 0, 0, 0, 0, 0));
      voxel_queue.push_back(pack_echoes(0, 0, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000));
      voxel_queue.push_back(pack_echoes(0, 0, 16'h8000, 0, 16'h1234, 16'h4321));
      voxel_queue.push_back(pack_echoes(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                        16'h7fff, 16'h7fff));
      voxel_queue.push_back(pack_echoes(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                        16'h8000, 16'h8000));
      voxel_queue.push_back(pack_echoes(16'h7fff, 0, 0, 0, 0, 0));
      voxel_queue.push_back(pack_echoes(16'h8000, 0, 16'h8000, 0, 16'h7fff, 0));
      voxel_queue.push_back(pack_echoes(0, 16'h7fff, 0, 16'h8000, 16'h8000, 0));
      voxel_queue.push_back(pack_echoes(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                                        16'h8000, 16'h7fff));
      voxel_queue.push_back(pack_echoes(1, 0, 0, 1, 16'hffff, 0));
      voxel_queue.push_back(pack_echoes(16'hffff, 16'hffff, 1, 1, 1, 16'hffff));
      for (int k = 0; k < 12; k++)
         voxel_queue.push_back(pack_echoes(ext[$urandom_range(0, 3)],
            ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
            ext[$urandom_range(0, 3)], ext[$urandom_range(0, 3)],
            ext[$urandom_range(0, 3)]));

      // random voxels, mostly full-range, some extremes, zeros and tiny parts
      for (int n = 0; n < NumRandom; n++) begin
         for (int k = 0; k < 6; k++)
            p[k] = rand_part(($urandom_range(0, 9) < 7) ? 4 : $urandom_range(0, 3));
         if ($urandom_range(0, 19) == 0) begin
            p[0] = 0;
            p[1] = 0;
         end
         voxel_queue.push_back(pack_echoes(p[0], p[1], p[2], p[3], p[4], p[5]));
      end
      total = voxel_queue.size();

      wait (sent_count >= total - 150);
      quiet_phase = 1'b1;
      wait (sent_count == total && expected_results.size() == 0);

      wait_cycles = 0;
      while (wait_cycles < Latency) begin
         @(posedge clock);
         wait_cycles++;
      end

      $display("Covered %0d voxels (%0d with zero first echo, %0d saturated levels)",
               got_count, zero_ref_count, sat_count);
      $display("with random gaps on both sides and one long output stall.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
